// ===== src/xssu_pkg.sv =====
package xssu_pkg;

  localparam int CS_W = 19;
  localparam int H_W = 21;
  localparam int NUM_W = 63;
  localparam int QUOT_BITS = 20;
  localparam logic [18:0] CORDIC_GAIN = 19'd39797;
  localparam logic [20:0] ACC_SCALE = 21'd1890960;
  localparam logic [15:0] LN2_Q16 = 16'd45426;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [5:0] TEMP_RESET = 6'd8;

  localparam logic CMD_METRO = 1'b0;
  localparam logic CMD_REFLECT = 1'b1;

  typedef struct packed {
    logic ovf;
    logic [QUOT_BITS-1:0] quot;
  } div_out_t;

  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    logic [31:0] v;
    case (i)
      4'd0: v = 32'h20000000;
      4'd1: v = 32'h12E4051E;
      4'd2: v = 32'h09FB385B;
      4'd3: v = 32'h051111D4;
      4'd4: v = 32'h028B0D43;
      4'd5: v = 32'h0145D7E1;
      4'd6: v = 32'h00A2F61E;
      4'd7: v = 32'h00517C55;
      4'd8: v = 32'h0028BE53;
      4'd9: v = 32'h00145F2F;
      4'd10: v = 32'h000A2F98;
      4'd11: v = 32'h000517CC;
      4'd12: v = 32'h00028BE6;
      4'd13: v = 32'h000145F3;
      4'd14: v = 32'h0000A2FA;
      4'd15: v = 32'h0000517D;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] exp2_neg16(input logic [3:0] i);
    logic [16:0] v;
    case (i)
      4'd0: v = 17'd65536;
      4'd1: v = 17'd62757;
      4'd2: v = 17'd60097;
      4'd3: v = 17'd57549;
      4'd4: v = 17'd55109;
      4'd5: v = 17'd52773;
      4'd6: v = 17'd50535;
      4'd7: v = 17'd48393;
      4'd8: v = 17'd46341;
      4'd9: v = 17'd44376;
      4'd10: v = 17'd42495;
      4'd11: v = 17'd40693;
      4'd12: v = 17'd38968;
      4'd13: v = 17'd37316;
      4'd14: v = 17'd35734;
      4'd15: v = 17'd34219;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // proposal half-width in Q32 turns, capped at a half turn
  function automatic logic [31:0] delta_q32(input logic [5:0] t);
    logic [32:0] s;
    s = 33'd615208748 + 33'd27342611 * 33'(t);
    return (s > 33'(HALF_TURN)) ? HALF_TURN : s[31:0];
  endfunction

endpackage

// ===== src/xssu_delay.sv =====
module xssu_delay #(
  parameter int W = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    taps[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

// ===== src/xssu_cordic_rot.sv =====
module xssu_cordic_rot #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                          clk,
  input  logic [ANGLE_BITS-1:0]         angle,
  output logic signed [xssu_pkg::CS_W-1:0] cos_out,
  output logic signed [xssu_pkg::CS_W-1:0] sin_out
);

  localparam int PH_SHIFT = 32 - ANGLE_BITS;
  localparam int W = xssu_pkg::CS_W;

  logic signed [W-1:0] x [17];
  logic signed [W-1:0] y [17];
  logic signed [31:0]  r [17];
  logic [1:0]          q [17];
  logic [31:0]         sh;

  assign sh = {angle, {PH_SHIFT{1'b0}}} + 32'h2000_0000;

  always_ff @(posedge clk) begin
    x[0] <= $signed(xssu_pkg::CORDIC_GAIN);
    y[0] <= '0;
    r[0] <= $signed({2'b00, sh[29:0]}) - 32'sh2000_0000;
    q[0] <= sh[31:30];
  end

  for (genvar i = 0; i < 16; i++) begin : g_iter
    always_ff @(posedge clk) begin
      q[i+1] <= q[i];
      if (r[i] >= 0) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        r[i+1] <= r[i] - $signed(xssu_pkg::atan_turn(4'(i)));
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        r[i+1] <= r[i] + $signed(xssu_pkg::atan_turn(4'(i)));
      end
    end
  end

  always_ff @(posedge clk) begin
    case (q[16])
      2'd0: begin
        cos_out <= x[16];
        sin_out <= y[16];
      end
      2'd1: begin
        cos_out <= -y[16];
        sin_out <= x[16];
      end
      2'd2: begin
        cos_out <= -x[16];
        sin_out <= -y[16];
      end
      default: begin
        cos_out <= y[16];
        sin_out <= -x[16];
      end
    endcase
  end

endmodule

// ===== src/xssu_cordic_vec.sv =====
module xssu_cordic_vec (
  input  logic                             clk,
  input  logic signed [xssu_pkg::H_W-1:0]  hx,
  input  logic signed [xssu_pkg::H_W-1:0]  hy,
  output logic [31:0]                      phase
);

  localparam int W = 23;

  logic signed [W-1:0] x [17];
  logic signed [W-1:0] y [17];
  logic [31:0]         z [17];
  logic                zero [17];

  always_ff @(posedge clk) begin
    zero[0] <= (hx == 0) && (hy == 0);
    if (hx < 0) begin
      x[0] <= -W'(hx);
      y[0] <= -W'(hy);
      z[0] <= xssu_pkg::HALF_TURN;
    end else begin
      x[0] <= W'(hx);
      y[0] <= W'(hy);
      z[0] <= '0;
    end
  end

  for (genvar i = 0; i < 16; i++) begin : g_iter
    always_ff @(posedge clk) begin
      zero[i+1] <= zero[i];
      if (y[i] > 0) begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + xssu_pkg::atan_turn(4'(i));
      end else begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - xssu_pkg::atan_turn(4'(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    phase <= zero[16] ? 32'd0 : z[16];
  end

endmodule

// ===== src/xssu_divider.sv =====
module xssu_divider (
  input  logic                           clk,
  input  logic [xssu_pkg::NUM_W-1:0]     num,
  input  logic [5:0]                     temperature,
  output xssu_pkg::div_out_t             result
);

  localparam int NW = xssu_pkg::NUM_W;
  localparam int QB = xssu_pkg::QUOT_BITS;

  logic [NW-1:0] rem  [QB+1];
  logic [QB-1:0] quot [QB+1];
  logic          ovf  [QB+1];

  always_ff @(posedge clk) begin
    ovf[0]  <= num >= (NW'(temperature) << (32 + QB));
    rem[0]  <= num;
    quot[0] <= '0;
  end

  for (genvar i = 0; i < QB; i++) begin : g_step
    localparam int B = QB - 1 - i;
    logic [NW-1:0] dsh;
    assign dsh = NW'(temperature) << (32 + B);
    always_ff @(posedge clk) begin
      ovf[i+1] <= ovf[i];
      if (rem[i] >= dsh) begin
        rem[i+1]  <= rem[i] - dsh;
        quot[i+1] <= quot[i] | (QB'(1) << B);
      end else begin
        rem[i+1]  <= rem[i];
        quot[i+1] <= quot[i];
      end
    end
  end

  assign result.ovf  = ovf[QB];
  assign result.quot = quot[QB];

endmodule

// ===== src/xy_spin_site_update.sv =====
// Channel   Handshake               Payload
// request   start / busy            cmd, site/neighbour angles, colours, rands
// result    done (one-cycle strobe) new_angle, changed
// config    cfg_valid / cfg_ready   cfg_data (temperature)
//
// Fully pipelined: one request per cycle, busy is never raised.
// The pipeline depth is set by the 16-step CORDIC lanes and the
// 20-step restoring divider of the acceptance test.
// rst (synchronous) clears the valid pipeline and sets temperature to 8.
// The receiver cannot stall; done marks each result for one cycle.
module xy_spin_site_update #(
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        cmd,
  input  logic [15:0] site_angle,
  input  logic [15:0] north_angle,
  input  logic [15:0] south_angle,
  input  logic [15:0] east_angle,
  input  logic [15:0] west_angle,
  input  logic        site_colour,
  input  logic        sweep_colour,
  input  logic [15:0] proposal_rand,
  input  logic [15:0] accept_rand,
  output logic [15:0] new_angle,
  output logic        changed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);

  localparam int AB = ANGLE_BITS;
  localparam int PH_SHIFT = 32 - AB;
  localparam int LAT = 51;
  localparam int CW = xssu_pkg::CS_W;
  localparam int HW = xssu_pkg::H_W;

  typedef struct packed {
    logic          cmd;
    logic          match;
    logic [AB-1:0] th;
    logic [AB-1:0] tn;
    logic [15:0]   u2;
  } side_t;

  typedef struct packed {
    side_t s;
    logic  le0;
    logic  lt0;
  } mside_t;

  logic [5:0]  temperature;
  logic [31:0] d32;
  logic [LAT-1:0] vpipe;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temperature <= xssu_pkg::TEMP_RESET;
      d32 <= xssu_pkg::delta_q32(xssu_pkg::TEMP_RESET);
      vpipe <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        temperature <= cfg_data;
        d32 <= xssu_pkg::delta_q32(cfg_data);
      end
      vpipe <= {vpipe[LAT-2:0], start && !busy};
    end
  end

  assign done = vpipe[LAT-1];

  // S0..S2: proposal
  logic          cmd0, match0;
  logic [AB-1:0] th0;
  logic [AB-1:0] nb0 [4];
  logic [15:0]   u1_0, u2_0;
  logic signed [50:0] prod1;
  logic          cmd1, match1;
  logic [AB-1:0] th1;
  logic [AB-1:0] nb1 [4];
  logic [15:0]   u2_1;
  side_t         side2;
  logic [AB-1:0] nb2 [4];
  logic signed [17:0] u1t;

  assign u1t = $signed({1'b0, u1_0, 1'b0}) - 18'sd65536;

  always_ff @(posedge clk) begin
    cmd0 <= cmd;
    match0 <= site_colour == sweep_colour;
    th0 <= AB'(site_angle);
    nb0[0] <= AB'(north_angle);
    nb0[1] <= AB'(south_angle);
    nb0[2] <= AB'(east_angle);
    nb0[3] <= AB'(west_angle);
    u1_0 <= proposal_rand;
    u2_0 <= accept_rand;

    prod1 <= 51'(u1t) * 51'($signed({1'b0, d32}));
    cmd1 <= cmd0;
    match1 <= match0;
    th1 <= th0;
    nb1 <= nb0;
    u2_1 <= u2_0;

    side2.cmd <= cmd1;
    side2.match <= match1;
    side2.th <= th1;
    side2.tn <= th1 + prod1[47:48-AB];
    side2.u2 <= u2_1;
    nb2 <= nb1;
  end

  // S2..S20: six rotation lanes (4 neighbours, th, tn)
  logic [AB-1:0]        lane_ang [6];
  logic signed [CW-1:0] lane_c [6];
  logic signed [CW-1:0] lane_s [6];

  assign lane_ang[0] = nb2[0];
  assign lane_ang[1] = nb2[1];
  assign lane_ang[2] = nb2[2];
  assign lane_ang[3] = nb2[3];
  assign lane_ang[4] = side2.th;
  assign lane_ang[5] = side2.tn;

  for (genvar l = 0; l < 6; l++) begin : g_lane
    xssu_cordic_rot #(.ANGLE_BITS(AB)) u_rot (
      .clk(clk),
      .angle(lane_ang[l]),
      .cos_out(lane_c[l]),
      .sin_out(lane_s[l])
    );
  end

  side_t side20;

  xssu_delay #(.W($bits(side_t)), .DEPTH(18)) u_dly_a (
    .clk(clk), .din(side2), .dout(side20)
  );

  // S21..S23: local field, trial differences and energy change dE
  logic signed [HW-1:0] hx21, hy21;
  logic signed [19:0]   dc21, ds21;
  side_t                side21, side22, side23;
  logic signed [40:0]   p1_22, p2_22;
  logic signed [41:0]   de23;

  always_ff @(posedge clk) begin
    hx21 <= HW'(lane_c[0]) + HW'(lane_c[1]) + HW'(lane_c[2]) + HW'(lane_c[3]);
    hy21 <= HW'(lane_s[0]) + HW'(lane_s[1]) + HW'(lane_s[2]) + HW'(lane_s[3]);
    dc21 <= 20'(lane_c[5]) - 20'(lane_c[4]);
    ds21 <= 20'(lane_s[5]) - 20'(lane_s[4]);
    side21 <= side20;

    p1_22 <= 41'(dc21) * 41'(hx21);
    p2_22 <= 41'(ds21) * 41'(hy21);
    side22 <= side21;

    de23 <= -42'(p1_22) - 42'(p2_22);
    side23 <= side22;
  end

  // S23..S25: scale dE for the divider
  logic [40:0] de_u;
  logic [40:0] hp24;
  logic [41:0] lp24;
  logic [xssu_pkg::NUM_W-1:0] num25;

  assign de_u = de23[40:0];

  always_ff @(posedge clk) begin
    hp24 <= 41'(de_u[40:21]) * 41'(xssu_pkg::ACC_SCALE);
    lp24 <= 42'(de_u[20:0]) * 42'(xssu_pkg::ACC_SCALE);
    num25 <= (xssu_pkg::NUM_W'(hp24) << 21) + xssu_pkg::NUM_W'(lp24);
  end

  xssu_pkg::div_out_t div46;

  xssu_divider u_div (
    .clk(clk), .num(num25), .temperature(temperature), .result(div46)
  );

  mside_t mside23, mside46;

  assign mside23.s = side23;
  assign mside23.le0 = de23 <= 0;
  assign mside23.lt0 = de23 < 0;

  xssu_delay #(.W($bits(mside_t)), .DEPTH(23)) u_dly_b (
    .clk(clk), .din(mside23), .dout(mside46)
  );

  // S21..S46: overrelaxation reflection
  logic [31:0]   phase39;
  logic [32:0]   dsum;
  logic [AB-1:0] a39, a46;

  xssu_cordic_vec u_vec (
    .clk(clk), .hx(hx21), .hy(hy21), .phase(phase39)
  );

  assign dsum = {1'b0, phase39[30:0], 1'b0} + (33'd1 << (31 - AB));
  assign a39 = dsum[31:PH_SHIFT];

  xssu_delay #(.W(AB), .DEPTH(7)) u_dly_c (
    .clk(clk), .din(a39), .dout(a46)
  );

  // S46..S50: acceptance probability and result
  mside_t        ms47, ms48, ms49;
  logic [AB-1:0] orx47, orx48, orx49;
  logic [28:0]   t1_47;
  logic [44:0]   t2_48;
  logic [16:0]   base47, base48, m49;
  logic [3:0]    k47, k48, k49;
  logic          ovf47, ovf48, ovf49;
  logic          acc;

  always_ff @(posedge clk) begin
    base47 <= xssu_pkg::exp2_neg16(div46.quot[15:12]);
    t1_47 <= 29'(xssu_pkg::exp2_neg16(div46.quot[15:12])) * 29'(div46.quot[11:0]);
    k47 <= div46.quot[19:16];
    ovf47 <= div46.ovf;
    ms47 <= mside46;
    orx47 <= a46 - mside46.s.th;

    t2_48 <= 45'(t1_47) * 45'(xssu_pkg::LN2_Q16);
    base48 <= base47;
    k48 <= k47;
    ovf48 <= ovf47;
    ms48 <= ms47;
    orx48 <= orx47;

    m49 <= base48 - 17'(t2_48[44:32]);
    k49 <= k48;
    ovf49 <= ovf48;
    ms49 <= ms48;
    orx49 <= orx48;
  end

  assign acc = (temperature == 6'd0) ? ms49.lt0
             : (ms49.le0 || (!ovf49 && (17'(ms49.s.u2) < (m49 >> k49))));

  always_ff @(posedge clk) begin
    if (!ms49.s.match) begin
      new_angle <= 16'(ms49.s.th);
      changed <= 1'b0;
    end else if (ms49.s.cmd == xssu_pkg::CMD_REFLECT) begin
      new_angle <= 16'(orx49);
      changed <= 1'b1;
    end else if (acc) begin
      new_angle <= 16'(ms49.s.tn);
      changed <= 1'b1;
    end else begin
      new_angle <= 16'(ms49.s.th);
      changed <= 1'b0;
    end
  end

  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without matching request");

  a_mismatch_unchanged: assert property (@(posedge clk) disable iff (rst)
    (vpipe[LAT-2] && !ms49.s.match) |=> (done && !changed))
    else $error("off-colour site reported as changed");

  a_reflect_changed: assert property (@(posedge clk) disable iff (rst)
    (vpipe[LAT-2] && ms49.s.match && ms49.s.cmd == xssu_pkg::CMD_REFLECT)
      |=> changed)
    else $error("reflection not reported as changed");

endmodule
